>>> rtl/atlv_pkg.sv
// Shared types, constants and the hex digit decoder for the ASCII TLV deframer.
// No dependencies; used by every module of the block.
package atlv_pkg;

  localparam int TYPE_CHARS_DEF    = 4;
  localparam int LENGTH_DIGITS_DEF = 4;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int BYTE_W   = 8;
  localparam int TYPE_W   = 32;
  localparam int LEN_W    = 16;
  localparam int NIBBLE_W = 4;
  localparam int TDATA_W  = 40;

  typedef struct packed {
    logic                header_error;
    logic                is_last;
    logic [BYTE_W-1:0]   payload_byte;
    logic [TYPE_W-1:0]   msg_type;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                valid;
    logic [NIBBLE_W-1:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = NIBBLE_W'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = NIBBLE_W'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = NIBBLE_W'(c - 8'h57);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> rtl/atlv_front.sv
// Front parser: takes one byte per transaction, tracks header and payload phases,
// and produces at most one result record per byte. Depends on atlv_pkg.
module atlv_front #(
  parameter int TYPE_CHARS    = atlv_pkg::TYPE_CHARS_DEF,
  parameter int LENGTH_DIGITS = atlv_pkg::LENGTH_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [atlv_pkg::BYTE_W-1:0] data_byte,
  output logic                        res_valid,
  output atlv_pkg::result_t           res
);

  localparam int MAX_CHARS = (TYPE_CHARS > LENGTH_DIGITS) ? TYPE_CHARS : LENGTH_DIGITS;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  logic [1:0]                  phase, phase_next;
  logic [CNT_W-1:0]            header_count, header_count_next;
  logic [atlv_pkg::TYPE_W-1:0] type_word, type_word_next;
  logic [atlv_pkg::LEN_W-1:0]  length_value, length_value_next;
  logic                        length_bad, length_bad_next;
  logic [atlv_pkg::LEN_W-1:0]  payload_remaining, payload_remaining_next;

  atlv_pkg::hex_t              hex;
  logic [CNT_W-1:0]            cnt_inc;
  logic [CNT_W-1:0]            cnt_base;
  logic [atlv_pkg::TYPE_W-1:0] type_base;
  logic [atlv_pkg::LEN_W-1:0]  len_acc;
  logic                        bad_acc;
  logic                        last;

  always_comb begin
    phase_next             = phase;
    header_count_next      = header_count;
    type_word_next         = type_word;
    length_value_next      = length_value;
    length_bad_next        = length_bad;
    payload_remaining_next = payload_remaining;
    res_valid              = 1'b0;
    res                    = '0;
    hex                    = atlv_pkg::hex_decode(data_byte);
    cnt_inc                = header_count + CNT_W'(1);
    cnt_base               = '0;
    type_base              = '0;
    len_acc                = length_value;
    bad_acc                = length_bad;
    last                   = (payload_remaining <= atlv_pkg::LEN_W'(1));

    unique case (phase)
      PH_PAY: begin
        res_valid          = 1'b1;
        res.msg_type       = type_word;
        res.payload_byte   = data_byte;
        res.is_last        = last;
        if (last) begin
          phase_next             = PH_TYPE;
          header_count_next      = '0;
          type_word_next         = '0;
          length_value_next      = '0;
          length_bad_next        = 1'b0;
          payload_remaining_next = '0;
        end else begin
          payload_remaining_next = payload_remaining - atlv_pkg::LEN_W'(1);
        end
      end
      PH_LEN: begin
        if (!hex.valid) begin
          bad_acc = 1'b1;
        end else if (length_value[atlv_pkg::LEN_W-1 -: atlv_pkg::NIBBLE_W] != '0) begin
          len_acc = '1;
        end else begin
          len_acc = {length_value[atlv_pkg::LEN_W-atlv_pkg::NIBBLE_W-1:0], hex.value};
        end
        length_value_next = len_acc;
        length_bad_next   = bad_acc;
        header_count_next = cnt_inc;
        if (cnt_inc >= CNT_W'(LENGTH_DIGITS)) begin
          if (bad_acc || len_acc == '0) begin
            res_valid              = bad_acc;
            res.msg_type           = type_word;
            res.header_error       = bad_acc;
            phase_next             = PH_TYPE;
            header_count_next      = '0;
            type_word_next         = '0;
            length_value_next      = '0;
            length_bad_next        = 1'b0;
            payload_remaining_next = '0;
          end else begin
            payload_remaining_next = len_acc;
            header_count_next      = '0;
            phase_next             = PH_PAY;
          end
        end
      end
      default: begin
        if (phase == PH_TYPE) begin
          type_base = type_word;
          cnt_base  = header_count;
        end else begin
          length_value_next      = '0;
          length_bad_next        = 1'b0;
          payload_remaining_next = '0;
        end
        type_word_next    = {type_base[atlv_pkg::TYPE_W-atlv_pkg::BYTE_W-1:0], data_byte};
        header_count_next = cnt_base + CNT_W'(1);
        phase_next        = PH_TYPE;
        if (header_count_next >= CNT_W'(TYPE_CHARS)) begin
          header_count_next = '0;
          length_value_next = '0;
          length_bad_next   = 1'b0;
          phase_next        = PH_LEN;
        end
      end
    endcase

    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TYPE;
      header_count      <= '0;
      type_word         <= '0;
      length_value      <= '0;
      length_bad        <= 1'b0;
      payload_remaining <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      type_word         <= type_word_next;
      length_value      <= length_value_next;
      length_bad        <= length_bad_next;
      payload_remaining <= payload_remaining_next;
    end
  end

endmodule

>>> rtl/atlv_queue.sv
// Short result queue between the parser and the output stage.
// Depends on atlv_pkg for the result record and status types.
module atlv_queue #(
  parameter int QUEUE_DEPTH = atlv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  atlv_pkg::result_t push_data,
  input  logic              pop,
  output atlv_pkg::result_t pop_data,
  output atlv_pkg::q_stat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  atlv_pkg::result_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/atlv_back.sv
// Output stage: registers one result record and drives the master stream.
// Depends on atlv_pkg for the result record layout.
module atlv_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  atlv_pkg::result_t            q_data,
  output logic                         q_pop,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [atlv_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser
);

  atlv_pkg::result_t out_reg;

  assign q_pop         = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign m_axis_tdata  = {out_reg.payload_byte, out_reg.msg_type};
  assign m_axis_tlast  = out_reg.is_last;
  assign m_axis_tuser  = out_reg.header_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_reg <= q_data;
    end
  end

endmodule

>>> rtl/ascii_tlv_message_deframer.sv
// ASCII type-length-value deframer: one received byte per transaction on the slave
// stream; one result per payload byte (or per bad header) on the master stream.
// Depends on atlv_pkg, atlv_front, atlv_queue and atlv_back.
//
// Takes one byte every clock cycle while the queue is not full. Each byte is parsed in the
// cycle it is accepted; its result, if any, is written into a QUEUE_DEPTH-entry queue and
// moves on into the output register whenever that register is free, so results leave at
// one per cycle while the master side accepts them. A result passes through the queue and
// the output register before it is offered on the master stream. The slave side stalls
// only while the queue is full, which happens only after the master side has held off
// for QUEUE_DEPTH+1 results. Headers and zero-length messages produce no result; a header
// whose length has a non-hex character gives one result with tuser set and zero payload.
module ascii_tlv_message_deframer #(
  parameter int TYPE_CHARS    = atlv_pkg::TYPE_CHARS_DEF,
  parameter int LENGTH_DIGITS = atlv_pkg::LENGTH_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = atlv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [atlv_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [atlv_pkg::TDATA_W-1:0] m_axis_tdata,   // [31:0] msg_type, [39:32] payload_byte
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser    // [0] header_error
);

  logic              accept;
  logic              res_valid;
  atlv_pkg::result_t res;
  logic              q_pop;
  atlv_pkg::result_t q_data;
  atlv_pkg::q_stat_t q_stat;

  assign s_axis_tready = !q_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  atlv_front #(
    .TYPE_CHARS    (TYPE_CHARS),
    .LENGTH_DIGITS (LENGTH_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  atlv_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  atlv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (!q_stat.empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !q_stat.full)
    else $error("result pushed into a full queue");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_stat.full && m_axis_tvalid)
    else $error("input stalled without a full queue and a held output");

  a_error_has_no_payload: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (!m_axis_tlast && m_axis_tdata[atlv_pkg::TDATA_W-1:atlv_pkg::TYPE_W] == '0))
    else $error("error result carries payload or last flag");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && !m_axis_tvalid) |-> q_pop)
    else $error("output register idle while queue holds a result");

endmodule

>>> dv/ascii_tlv_message_deframer_tb.sv
// Self-checking testbench for ascii_tlv_message_deframer: byte stream in, results out.
// Uses atlv_pkg for widths and the result layout. Drives a directed table, then random messages.
module ascii_tlv_message_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  N_TYPE      = atlv_pkg::TYPE_CHARS_DEF;
  localparam int  N_DIGITS    = atlv_pkg::LENGTH_DIGITS_DEF;
  localparam int  RANDOM_TO   = 725;
  localparam int  SQUEEZE_AT  = 300;
  localparam int  SQUEEZE_LEN = 200;
  localparam int  DRAIN       = 20;
  localparam int  CYCLE_LIMIT = 300000;

  typedef enum logic [1:0] {SCAN_TYPE, SCAN_LEN, SCAN_PAYLOAD} scan_phase_t;
  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_RESULT} row_kind_t;

  typedef struct packed {
    logic [atlv_pkg::BYTE_W-1:0] data;
    row_kind_t                   kind;
    atlv_pkg::result_t           res;
  } byte_row_t;

  localparam byte_row_t DIRECTED [25] = '{
    '{8'h41, ROW_NONE,   '0},
    '{8'h42, ROW_NONE,   '0},
    '{8'h43, ROW_NONE,   '0},
    '{8'h44, ROW_NONE,   '0},
    '{8'h30, ROW_NONE,   '0},
    '{8'h30, ROW_NONE,   '0},
    '{8'h30, ROW_NONE,   '0},
    '{8'h31, ROW_NONE,   '0},
    '{8'hFF, ROW_RESULT, '{1'b0, 1'b1, 8'hFF, 32'h41424344}},
    '{8'hFF, ROW_PRED,   '0},
    '{8'h00, ROW_PRED,   '0},
    '{8'h7F, ROW_PRED,   '0},
    '{8'h80, ROW_PRED,   '0},
    '{8'h2F, ROW_PRED,   '0},
    '{8'h3A, ROW_PRED,   '0},
    '{8'h47, ROW_PRED,   '0},
    '{8'h67, ROW_RESULT, '{1'b1, 1'b0, 8'h00, 32'hFF007F80}},
    '{8'h7A, ROW_PRED,   '0},
    '{8'h7A, ROW_PRED,   '0},
    '{8'h7A, ROW_PRED,   '0},
    '{8'h7A, ROW_PRED,   '0},
    '{8'h30, ROW_PRED,   '0},
    '{8'h30, ROW_PRED,   '0},
    '{8'h30, ROW_PRED,   '0},
    '{8'h30, ROW_PRED,   '0}
  };

  logic                         clk;
  logic                         rst;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [atlv_pkg::BYTE_W-1:0]  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [atlv_pkg::TDATA_W-1:0] m_axis_tdata;
  logic                         m_axis_tlast;
  logic                         m_axis_tuser;

  ascii_tlv_message_deframer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  byte_row_t         stream_bytes [$];
  atlv_pkg::result_t pending_results [$];
  scan_phase_t       scan_phase;
  int                hdr_count;
  logic [31:0]       type_acc;
  logic [15:0]       len_acc;
  bit                len_invalid;
  logic [15:0]       pay_left;
  int                n_bytes_in;
  int                n_results;
  int                n_header_errors;
  int                n_last;
  int                n_mismatch;
  int                cycle_count;
  bit                squeezed;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_scan();
    scan_phase  = SCAN_TYPE;
    hdr_count   = 0;
    type_acc    = '0;
    len_acc     = '0;
    len_invalid = 1'b0;
    pay_left    = '0;
  endfunction

  function automatic int hex_nibble(input logic [atlv_pkg::BYTE_W-1:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic bit deframe_step(input logic [atlv_pkg::BYTE_W-1:0] b,
                                      output atlv_pkg::result_t r);
    int          nib;
    logic [19:0] grown;
    bit          emit;
    emit = 1'b0;
    r    = '0;
    case (scan_phase)
      SCAN_PAYLOAD: begin
        r.msg_type     = type_acc;
        r.payload_byte = b;
        r.is_last      = (pay_left <= 16'd1);
        emit           = 1'b1;
        if (r.is_last) clear_scan();
        else pay_left = pay_left - 16'd1;
      end
      SCAN_LEN: begin
        nib = hex_nibble(b);
        if (nib < 0) begin
          len_invalid = 1'b1;
        end else begin
          grown   = {len_acc, 4'(nib)};
          len_acc = (grown > 20'hFFFF) ? 16'hFFFF : grown[15:0];
        end
        hdr_count++;
        if (hdr_count >= N_DIGITS) begin
          if (len_invalid) begin
            r.msg_type     = type_acc;
            r.header_error = 1'b1;
            emit           = 1'b1;
            clear_scan();
          end else if (len_acc == '0) begin
            clear_scan();
          end else begin
            pay_left   = len_acc;
            hdr_count  = 0;
            scan_phase = SCAN_PAYLOAD;
          end
        end
      end
      default: begin
        if (scan_phase != SCAN_TYPE) clear_scan();
        type_acc = {type_acc[23:0], b};
        hdr_count++;
        if (hdr_count >= N_TYPE) begin
          hdr_count   = 0;
          len_acc     = '0;
          len_invalid = 1'b0;
          scan_phase  = SCAN_LEN;
        end
      end
    endcase
    return emit;
  endfunction

  function automatic logic [atlv_pkg::BYTE_W-1:0] hex_char(input int n);
    if (n < 10) return 8'(int'("0") + n);
    if ($urandom_range(0, 1) == 0) return 8'(int'("A") + n - 10);
    return 8'(int'("a") + n - 10);
  endfunction

  function automatic logic [atlv_pkg::BYTE_W-1:0] non_hex_byte();
    logic [atlv_pkg::BYTE_W-1:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_nibble(c) >= 0) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic void push_byte(input logic [atlv_pkg::BYTE_W-1:0] b);
    byte_row_t row;
    row.data = b;
    row.kind = ROW_PRED;
    row.res  = '0;
    stream_bytes.push_back(row);
  endfunction

  // Mostly well-formed messages; the rest zero-length, bad-length or garbage headers.
  function automatic void add_random_message();
    int r;
    int len;
    int bad_pos;
    r = $urandom_range(0, 99);
    for (int i = 0; i < N_TYPE; i++) push_byte(8'($urandom_range(0, 255)));
    if (r < 80) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      for (int i = N_DIGITS - 1; i >= 0; i--) push_byte(hex_char((len >> (4 * i)) & 15));
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
    end else if (r < 85) begin
      for (int i = 0; i < N_DIGITS; i++) push_byte(hex_char(0));
    end else if (r < 95) begin
      bad_pos = $urandom_range(0, N_DIGITS - 1);
      for (int i = 0; i < N_DIGITS; i++) begin
        if (i == bad_pos) push_byte(non_hex_byte());
        else push_byte(hex_char($urandom_range(0, 15)));
      end
    end else begin
      for (int i = 0; i < N_DIGITS; i++) push_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input atlv_pkg::result_t want,
                                 input atlv_pkg::result_t got);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("[%0t] %s: expected type=%h byte=%h last=%b err=%b,",
               $realtime, what, want.msg_type, want.payload_byte, want.is_last,
               want.header_error);
      $display("    got type=%h byte=%h last=%b err=%b",
               got.msg_type, got.payload_byte, got.is_last, got.header_error);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    byte_row_t         row;
    atlv_pkg::result_t pred;
    atlv_pkg::result_t want;
    atlv_pkg::result_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        row = stream_bytes[n_bytes_in];
        n_bytes_in++;
        if (deframe_step(row.data, pred) && row.kind == ROW_PRED) pending_results.push_back(pred);
        if (row.kind == ROW_RESULT) pending_results.push_back(row.res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.msg_type     = m_axis_tdata[atlv_pkg::TYPE_W-1:0];
        got.payload_byte = m_axis_tdata[atlv_pkg::TYPE_W +: atlv_pkg::BYTE_W];
        got.is_last      = m_axis_tlast;
        got.header_error = m_axis_tuser;
        n_results++;
        if (got.header_error) n_header_errors++;
        if (got.is_last) n_last++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transaction", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.msg_type !== want.msg_type || got.payload_byte !== want.payload_byte ||
              got.is_last !== want.is_last || got.header_error !== want.header_error) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
    end
  end

  // Receiver: random hold-offs, idle-free stretches, and one long squeeze mid-run.
  initial begin
    int stall_left;
    stall_left    = 0;
    squeezed      = 1'b0;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!squeezed && n_bytes_in >= SQUEEZE_AT) begin
        squeezed      = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(negedge clk);
      end else if (((cycle_count / 400) % 4) == 1) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left    = pick_gap();
        m_axis_tready <= 1'b0;
      end
      @(negedge clk);
    end
  end

  initial begin
    int gap;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    n_bytes_in    = 0;
    n_results     = 0;
    n_header_errors = 0;
    n_last        = 0;
    n_mismatch    = 0;
    cycle_count   = 0;
    clear_scan();
    foreach (DIRECTED[i]) stream_bytes.push_back(DIRECTED[i]);
    while (stream_bytes.size() < RANDOM_TO) add_random_message();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < stream_bytes.size(); i++) begin
      gap = (((i / 50) % 4) == 1) ? 0 : pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= stream_bytes[i].data;
      do @(posedge clk); while (!s_axis_tready);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    n_mismatch += pending_results.size();
    $display("covered %0d input bytes, %0d results checked (%0d message ends, %0d bad headers)",
             n_bytes_in, n_results, n_last, n_header_errors);
    $display("long output hold-off applied: %0d, mismatches: %0d", squeezed, n_mismatch);
    if (n_mismatch == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> ascii_tlv_message_deframer.f
rtl/atlv_pkg.sv
rtl/atlv_front.sv
rtl/atlv_queue.sv
rtl/atlv_back.sv
rtl/ascii_tlv_message_deframer.sv
dv/ascii_tlv_message_deframer_tb.sv
